// ----- design/char_lcd_nibble_interface_assert.svh -----
// Assertion helpers for the character LCD bus sequencer.
// Each check is compiled out when SYNTHESIS is defined.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CLNIB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clnib check failed");
// Next-cycle implication
`define CLNIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clnib check failed");
`else
`define CLNIB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CLNIB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/clnib_pkg.sv -----
package clnib_pkg;

   // Command codes carried in the input beat
   typedef enum logic [2:0] {
      CMD_CHAR     = 3'd0,
      CMD_RAW      = 3'd1,
      CMD_POSITION = 3'd2,
      CMD_HOME     = 3'd3,
      CMD_CLEAR    = 3'd4,
      CMD_DISPLAY  = 3'd5,
      CMD_CURSOR   = 3'd6,
      CMD_BLINK    = 3'd7
   } command_type;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_COLUMNS  = 2'd0;
   localparam logic [1:0] REG_ROWS     = 2'd1;
   localparam logic [1:0] REG_BUS_8BIT = 2'd2;

   // Controller command bytes
   localparam logic [7:0] CLEAR_DISPLAY_CMD = 8'h01;
   localparam logic [7:0] RETURN_HOME_CMD   = 8'h02;
   localparam logic [7:0] LCD_DISP_CTRL     = 8'h08;
   localparam logic [7:0] LCD_SET_DDRAM     = 8'h80;
   localparam logic [7:0] LCD_ROW1_OFFSET   = 8'h40;
   localparam logic [3:0] NIBBLE_MASK       = 4'hF;

   // Display control bits
   localparam logic [2:0] DC_DISPLAY = 3'b100;
   localparam logic [2:0] DC_CURSOR  = 3'b010;
   localparam logic [2:0] DC_BLINK   = 3'b001;

   // Reset values of the configuration registers
   localparam logic [5:0] COLUMNS_RESET = 6'd16;
   localparam logic [2:0] ROWS_RESET    = 3'd2;

   typedef struct packed {
      logic [5:0] columns;
      logic [2:0] rows;
      logic       bus_8bit;
   } config_type;

   typedef struct packed {
      logic [5:0] col;
      logic [1:0] row;
      logic [2:0] dc;
   } state_type;

   // Up to two bytes for the bus, with their register select
   typedef struct packed {
      logic       emit;
      logic       two_bytes;
      logic       wide;
      logic       rs0;
      logic [7:0] byte0;
      logic       rs1;
      logic [7:0] byte1;
   } burst_type;

endpackage

// ----- design/char_lcd_nibble_interface.sv -----
// Character LCD bus sequencer.
// The req channel takes one command per beat: tuser holds the command code,
// tdata holds data_byte, column, row and switch_on. The rsp channel gives
// the bus transfers: tdata is the nibble (4-bit mode) or byte, tuser the
// register select, tlast marks the final transfer of one command.
// A command makes one to four transfers; a position past the column count
// or the row count makes none. The first transfer is shown the cycle after
// the command is taken, and one transfer leaves per cycle while rsp_tready
// is high. The next command is taken in the cycle the last transfer leaves;
// that output holding register sets the rate. Cursor and display control
// are updated when the command is taken.
// The csr port holds columns (0x0), rows (0x4) and bus_8bit (0x8).
// Reset clears cursor and display control, sets 16 columns, 2 rows and
// 4-bit mode, and empties the output. A stall on rsp holds the current
// transfer and, once that register is full, stalls req.
module char_lcd_nibble_interface (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], column[13:8], row[15:14], switch_on[16]
   input  logic [2:0]  req_tuser,   // command[2:0]
   // transfer stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // bus_value[7:0]
   output logic        rsp_tuser,   // reg_select[0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import clnib_pkg::*;
   `include "char_lcd_nibble_interface_assert.svh"

   config_type  cfg_ff;
   state_type   state_ff;
   state_type   state_in;
   burst_type   burst;
   command_type command;
   logic        req_accept;
   logic        csr_write;
   logic [1:0]  csr_index;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns  <= COLUMNS_RESET;
         cfg_ff.rows     <= ROWS_RESET;
         cfg_ff.bus_8bit <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_COLUMNS:  cfg_ff.columns  <= csr_pwdata[5:0];
            REG_ROWS:     cfg_ff.rows     <= csr_pwdata[2:0];
            REG_BUS_8BIT: cfg_ff.bus_8bit <= csr_pwdata[0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COLUMNS:  csr_prdata = {26'b0, cfg_ff.columns};
         REG_ROWS:     csr_prdata = {29'b0, cfg_ff.rows};
         REG_BUS_8BIT: csr_prdata = {31'b0, cfg_ff.bus_8bit};
         default:      csr_prdata = '0;
      endcase
   end

   // Decode one command against the current cursor
   assign command    = command_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;

   clnib_decode u_decode (
      .command    (command),
      .data_byte  (req_tdata[7:0]),
      .column     (req_tdata[13:8]),
      .row        (req_tdata[15:14]),
      .switch_on  (req_tdata[16]),
      .cfg        (cfg_ff),
      .state_now  (state_ff),
      .burst      (burst),
      .state_next (state_in)
   );

   // Cursor and display control advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Output holding register and beat sequencing
   clnib_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .burst      (burst),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Home and clear put the cursor at the origin
   `CLNIB_ASSERT_NEXT(a_home_origin, clock, reset, req_accept && (command == CMD_HOME || command == CMD_CLEAR), state_ff.col == 6'd0 && state_ff.row == 2'd0)
   // Display control commands always produce transfers
   `CLNIB_ASSERT_NEXT(a_dc_emits, clock, reset, req_accept && (command == CMD_DISPLAY || command == CMD_CURSOR || command == CMD_BLINK), rsp_tvalid)
   // Nothing follows the final beat unless a new command was taken
   `CLNIB_ASSERT_NEXT(a_no_extra, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast && !req_accept, !rsp_tvalid)
   // Nibble mode keeps the upper bus bits clear
   `CLNIB_ASSERT_IMPLY(a_nibble_clean, clock, reset, rsp_tvalid && !cfg_ff.bus_8bit, rsp_tdata[7:4] == 4'h0)

endmodule

// ----- design/clnib_decode.sv -----
module clnib_decode (
   input  clnib_pkg::command_type command,
   input  logic [7:0]             data_byte,
   input  logic [5:0]             column,
   input  logic [1:0]             row,
   input  logic                   switch_on,
   input  clnib_pkg::config_type  cfg,
   input  clnib_pkg::state_type   state_now,
   output clnib_pkg::burst_type   burst,
   output clnib_pkg::state_type   state_next
);
   import clnib_pkg::*;

   logic [6:0] col_inc;
   logic       col_wrap;
   logic [2:0] row_inc;
   logic [1:0] row_adv;
   logic [7:0] wrap_addr;
   logic       pos_bad;
   logic [7:0] pos_addr;
   logic [2:0] dc_bit;
   logic [2:0] dc_new;

   // Cursor advance after a character
   assign col_inc   = {1'b0, state_now.col} + 7'd1;
   assign col_wrap  = col_inc >= {1'b0, cfg.columns};
   assign row_inc   = {1'b0, state_now.row} + 3'd1;
   assign row_adv   = (row_inc >= cfg.rows) ? 2'd0 : row_inc[1:0];
   assign wrap_addr = LCD_SET_DDRAM | ((row_adv != 2'd0) ? LCD_ROW1_OFFSET : 8'h00);

   // Position check and address
   assign pos_bad  = (column > cfg.columns) || ({1'b0, row} > cfg.rows);
   assign pos_addr = {2'b00, column}
                     + (LCD_SET_DDRAM | ((row != 2'd0) ? LCD_ROW1_OFFSET : 8'h00));

   // Display control update
   always_comb begin
      case (command)
         CMD_DISPLAY: dc_bit = DC_DISPLAY;
         CMD_CURSOR:  dc_bit = DC_CURSOR;
         default:     dc_bit = DC_BLINK;
      endcase
   end
   assign dc_new = switch_on ? (state_now.dc | dc_bit) : (state_now.dc & ~dc_bit);

   // Build the bytes and the next cursor state
   always_comb begin
      burst           = '0;
      burst.wide      = cfg.bus_8bit;
      burst.emit      = 1'b1;
      state_next      = state_now;
      case (command)
         CMD_CHAR: begin
            burst.rs0   = 1'b1;
            burst.byte0 = data_byte;
            if (col_wrap) begin
               burst.two_bytes = 1'b1;
               burst.byte1     = wrap_addr;
               state_next.col  = '0;
               state_next.row  = row_adv;
            end else begin
               state_next.col = col_inc[5:0];
            end
         end
         CMD_RAW: begin
            burst.byte0 = data_byte;
         end
         CMD_POSITION: begin
            if (pos_bad) begin
               burst.emit = 1'b0;
            end else begin
               burst.byte0    = pos_addr;
               state_next.col = column;
               state_next.row = row;
            end
         end
         CMD_HOME: begin
            burst.byte0    = RETURN_HOME_CMD;
            state_next.col = '0;
            state_next.row = '0;
         end
         CMD_CLEAR: begin
            burst.two_bytes = 1'b1;
            burst.byte0     = CLEAR_DISPLAY_CMD;
            burst.byte1     = RETURN_HOME_CMD;
            state_next.col  = '0;
            state_next.row  = '0;
         end
         default: begin
            burst.byte0   = LCD_DISP_CTRL | {5'b0, dc_new};
            state_next.dc = dc_new;
         end
      endcase
   end

endmodule

// ----- design/clnib_serializer.sv -----
module clnib_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  clnib_pkg::burst_type burst,
   output logic                 ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // bus_value[7:0]
   output logic                 rsp_tuser,   // reg_select
   output logic                 rsp_tlast
);
   import clnib_pkg::*;

   logic       valid_ff;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic [1:0] last_idx_ff;
   logic       wide_ff;
   logic       rs0_ff;
   logic       rs1_ff;
   logic [7:0] byte0_ff;
   logic [7:0] byte1_ff;
   logic       at_last;
   logic       sel;
   logic [7:0] byte_sel;

   assign at_last = idx_ff == last_idx_ff;
   assign ready   = !valid_ff || (rsp_tready && at_last);
   assign idx_in  = ready ? 2'd0 : (rsp_tready ? idx_ff + 2'd1 : idx_ff);

   // Control: hold the burst until its final beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (ready) begin
            valid_ff <= load && burst.emit;
         end
      end
   end

   // Payload: capture a new burst
   always_ff @(posedge clock) begin
      if (ready && load) begin
         wide_ff     <= burst.wide;
         rs0_ff      <= burst.rs0;
         rs1_ff      <= burst.rs1;
         byte0_ff    <= burst.byte0;
         byte1_ff    <= burst.byte1;
         last_idx_ff <= burst.wide ? {1'b0, burst.two_bytes} : {burst.two_bytes, 1'b1};
      end
   end

   // Pick byte and nibble for the current beat, high nibble first
   assign sel        = wide_ff ? idx_ff[0] : idx_ff[1];
   assign byte_sel   = sel ? byte1_ff : byte0_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = sel ? rs1_ff : rs0_ff;
   assign rsp_tlast  = at_last;
   assign rsp_tdata  = wide_ff ? byte_sel
                     : {4'b0, (idx_ff[0] ? byte_sel[3:0] : byte_sel[7:4]) & NIBBLE_MASK};

endmodule

// ----- tb/char_lcd_bus_checker.sv -----
`timescale 1ns / 100ps

module char_lcd_bus_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], column[13:8], row[15:14], switch_on[16]
   input  logic [2:0]  req_tuser,   // command[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // bus_value[7:0]
   input  logic        rsp_tuser,   // reg_select[0]
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int unsigned mismatches,
   output int unsigned transfers_checked,
   output int unsigned pending
);
   import clnib_pkg::*;

   typedef struct packed {
      logic       rs;
      logic [7:0] value;
      logic       last;
   } lcd_transfer_type;

   // Transfers still owed by the block, oldest first
   lcd_transfer_type bus_transfers_due[$];

   // Shadow geometry and bus width
   logic [5:0] geo_columns;
   logic [2:0] geo_rows;
   logic       geo_wide;

   // Shadow cursor and display control bits
   logic [5:0] cur_col;
   logic [1:0] cur_row;
   logic [2:0] disp_bits;

   function automatic logic [7:0] ddram_address(logic [5:0] col, logic [1:0] row);
      logic [7:0] base;
      base = LCD_SET_DDRAM | ((row != 2'd0) ? LCD_ROW1_OFFSET : 8'h00);
      return base + {2'b00, col};
   endfunction

   // Queue one byte as one beat (8-bit bus) or two nibble beats
   task automatic queue_byte(logic rs, logic [7:0] b);
      if (geo_wide) begin
         bus_transfers_due.push_back('{rs: rs, value: b, last: 1'b0});
      end else begin
         bus_transfers_due.push_back('{rs: rs, value: {4'h0, b[7:4]}, last: 1'b0});
         bus_transfers_due.push_back('{rs: rs, value: {4'h0, b[3:0]}, last: 1'b0});
      end
   endtask

   // Work out the transfers one command causes and advance the shadow state
   task automatic predict_bus_transfers(command_type cmd, logic [7:0] data,
                                        logic [5:0] col, logic [1:0] row, logic on);
      int start;
      logic [2:0] bit_sel;
      start = bus_transfers_due.size();
      case (cmd)
         CMD_CHAR: begin
            queue_byte(1'b1, data);
            if (int'(cur_col) + 1 >= int'(geo_columns)) begin
               cur_col = 6'd0;
               if (int'(cur_row) + 1 >= int'(geo_rows))
                  cur_row = 2'd0;
               else
                  cur_row = cur_row + 2'd1;
               queue_byte(1'b0, ddram_address(cur_col, cur_row));
            end else begin
               cur_col = cur_col + 6'd1;
            end
         end
         CMD_RAW: queue_byte(1'b0, data);
         CMD_POSITION: begin
            // out of range: nothing on the bus, cursor kept
            if (!(int'(col) > int'(geo_columns) || int'(row) > int'(geo_rows))) begin
               queue_byte(1'b0, ddram_address(col, row));
               cur_col = col;
               cur_row = row;
            end
         end
         CMD_HOME: begin
            queue_byte(1'b0, RETURN_HOME_CMD);
            cur_col = 6'd0;
            cur_row = 2'd0;
         end
         CMD_CLEAR: begin
            queue_byte(1'b0, CLEAR_DISPLAY_CMD);
            queue_byte(1'b0, RETURN_HOME_CMD);
            cur_col = 6'd0;
            cur_row = 2'd0;
         end
         default: begin
            bit_sel = (cmd == CMD_DISPLAY) ? DC_DISPLAY :
                      (cmd == CMD_CURSOR)  ? DC_CURSOR  : DC_BLINK;
            if (on)
               disp_bits = disp_bits | bit_sel;
            else
               disp_bits = disp_bits & ~bit_sel;
            queue_byte(1'b0, LCD_DISP_CTRL | {5'b00000, disp_bits});
         end
      endcase
      if (bus_transfers_due.size() > start)
         bus_transfers_due[bus_transfers_due.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin : monitor
      lcd_transfer_type due;
      if (reset) begin
         bus_transfers_due.delete();
         mismatches = 0;
         transfers_checked = 0;
         geo_columns = COLUMNS_RESET;
         geo_rows = ROWS_RESET;
         geo_wide = 1'b0;
         cur_col = 6'd0;
         cur_row = 2'd0;
         disp_bits = 3'd0;
      end else begin
         // compare the beat leaving the block with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (bus_transfers_due.size() == 0) begin
               $display("%0t: unexpected transfer rs=%b value=%h last=%b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               due = bus_transfers_due.pop_front();
               transfers_checked++;
               if (rsp_tuser !== due.rs) begin
                  $display("%0t: reg_select expected %b actual %b", $time, due.rs, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== due.value) begin
                  $display("%0t: bus_value expected %h actual %h",
                           $time, due.value, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== due.last) begin
                  $display("%0t: last expected %b actual %b", $time, due.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         // predict from each accepted command beat
         if (req_tvalid && req_tready)
            predict_bus_transfers(command_type'(req_tuser), req_tdata[7:0],
                                  req_tdata[13:8], req_tdata[15:14], req_tdata[16]);
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_COLUMNS:  geo_columns = csr_pwdata[5:0];
               REG_ROWS:     geo_rows = csr_pwdata[2:0];
               REG_BUS_8BIT: geo_wide = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      pending <= bus_transfers_due.size();
   end

endmodule

// ----- tb/tb_char_lcd_nibble_interface.sv -----
`timescale 1ns / 100ps

module tb_char_lcd_nibble_interface;
   import clnib_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL = 250;
   localparam int SETTLE_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // data_byte[7:0], column[13:8], row[15:14], switch_on[16]
   logic [2:0]  req_tuser;   // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // bus_value[7:0]
   logic        rsp_tuser;   // reg_select[0]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned mismatches;
   int unsigned transfers_checked;
   int unsigned pending;

   int unsigned cycle_count = 0;
   int unsigned commands_sent;
   int unsigned settings_used;
   int          long_stalls_asked;
   int          long_stalls_done;
   int          rx_hold;
   logic        calm;
   logic        burst;
   int          geo_cols;
   int          geo_rows;

   char_lcd_nibble_interface dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   char_lcd_bus_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatches        (mismatches),
      .transfers_checked (transfers_checked),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d transfers outstanding",
                  cycle_count, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold <= 0;
         long_stalls_done <= 0;
      end else if (long_stalls_done != long_stalls_asked) begin
         long_stalls_done <= long_stalls_asked;
         rx_hold <= LONG_STALL - 1;
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         rx_hold <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one command beat and hold it until taken
   task automatic send_command(command_type cmd, logic [7:0] data, logic [5:0] col,
                               logic [1:0] row, logic on);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'b0000000, on, row, col, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      commands_sent++;
      if (!calm && !burst && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed transfer has left
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_geometry(int cols, int rows, logic wide);
      wait_drained();
      csr_write(REG_COLUMNS, cols);
      csr_write(REG_ROWS, rows);
      csr_write(REG_BUS_8BIT, {31'd0, wide});
      geo_cols = cols;
      geo_rows = rows;
      settings_used++;
   endtask

   // Mostly characters and in-range positions, with the rest as noise
   task automatic send_random_command();
      int pick;
      command_type cmd;
      logic [5:0] col;
      logic [1:0] row;
      pick = $urandom_range(0, 99);
      col = 6'($urandom);
      row = 2'($urandom);
      if (pick < 45) begin
         cmd = CMD_CHAR;
      end else if (pick < 65) begin
         cmd = CMD_POSITION;
         if ($urandom_range(0, 4) != 0) begin
            col = 6'($urandom_range(0, (geo_cols > 63) ? 63 : geo_cols));
            row = 2'($urandom_range(0, (geo_rows > 3) ? 3 : geo_rows));
         end
      end else begin
         cmd = command_type'($urandom_range(1, 7));
      end
      send_command(cmd, 8'($urandom), col, row, 1'($urandom));
   endtask

   task automatic random_phase(int count);
      repeat (count) send_random_command();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_CHAR;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      csr_pready = 1'b1;
      commands_sent = 0;
      settings_used = 1;
      long_stalls_asked = 0;
      calm = 1'b0;
      burst = 1'b0;
      geo_cols = 16;
      geo_rows = 2;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset geometry, every command and the boundaries
      send_command(CMD_RAW, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_RAW, 8'hFF, 6'd63, 2'd3, 1'b1);
      send_command(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b1);
      send_command(CMD_CURSOR, 8'h00, 6'd0, 2'd0, 1'b1);
      send_command(CMD_BLINK, 8'h00, 6'd0, 2'd0, 1'b1);
      send_command(CMD_BLINK, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b1);
      send_command(CMD_HOME, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_CLEAR, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_CHAR, 8'h00, 6'd0, 2'd0, 1'b0);
      send_command(CMD_CHAR, 8'hFF, 6'd0, 2'd0, 1'b0);
      // position exactly at the size is still accepted
      send_command(CMD_POSITION, 8'h00, 6'd16, 2'd2, 1'b0);
      // positions past the size are dropped
      send_command(CMD_POSITION, 8'h00, 6'd17, 2'd0, 1'b0);
      send_command(CMD_POSITION, 8'h00, 6'd0, 2'd3, 1'b0);
      send_command(CMD_POSITION, 8'h00, 6'd63, 2'd3, 1'b0);
      // column wrap on the last row returns to row 0
      send_command(CMD_POSITION, 8'h00, 6'd15, 2'd1, 1'b0);
      send_command(CMD_CHAR, 8'h41, 6'd0, 2'd0, 1'b0);
      // column wrap on row 0 moves to row 1
      send_command(CMD_POSITION, 8'h00, 6'd14, 2'd0, 1'b0);
      send_command(CMD_CHAR, 8'h42, 6'd0, 2'd0, 1'b0);
      send_command(CMD_CHAR, 8'h43, 6'd0, 2'd0, 1'b0);
      send_command(CMD_POSITION, 8'h00, 6'd0, 2'd0, 1'b0);

      random_phase(40);

      // One-cell display on the byte-wide bus: every character wraps
      set_geometry(1, 1, 1'b1);
      random_phase(35);

      // 40 by 4 display, nibble bus
      set_geometry(40, 4, 1'b0);
      random_phase(45);

      // Long receiver hold-off while commands keep coming
      set_geometry(40, 4, 1'b1);
      long_stalls_asked <= long_stalls_asked + 1;
      burst = 1'b1;
      random_phase(20);
      burst = 1'b0;
      wait_drained();
      random_phase(20);

      // Zero size and oversized row count
      set_geometry(0, 0, 1'b0);
      random_phase(20);
      set_geometry(63, 7, 1'b1);
      random_phase(25);

      set_geometry($urandom_range(1, 40), $urandom_range(1, 4), 1'($urandom));
      random_phase(45);

      // Final stretch without idling on either side
      set_geometry($urandom_range(1, 40), $urandom_range(1, 4), 1'($urandom));
      calm <= 1'b1;
      random_phase(60);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d commands across %0d display settings, checked %0d bus transfers",
               commands_sent, settings_used, transfers_checked);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/clnib_pkg.sv
design/clnib_decode.sv
design/clnib_serializer.sv
design/char_lcd_nibble_interface.sv
tb/char_lcd_bus_checker.sv
tb/tb_char_lcd_nibble_interface.sv
